// ===== rtl/qalu_pkg.sv =====
// ----------------------------------------------------------------------------
// qalu_pkg
// Shared types and constants of the fixed-point quaternion unit.
// ----------------------------------------------------------------------------
package qalu_pkg;

  localparam int QALU_FRAC_BITS = 24;

  localparam logic [31:0] SAT_MAX = 32'h7fff_ffff;
  localparam logic [31:0] SAT_MIN = 32'h8000_0000;

  localparam logic [1:0] ROW_LAST = 2'd2;

  typedef enum logic [2:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_INV = 3'd3,
    CMD_ROT = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_ZERO = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } div_state_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [1:0] row;
    logic       last;
  } tag_t;

  typedef struct packed {
    logic start;
    logic ack;
  } div_ctl_t;

endpackage

// ===== rtl/qalu_mul.sv =====
// ----------------------------------------------------------------------------
// qalu_mul
// Operand register and sixteen registered products of a with b, each shifted
// right arithmetically by the fraction width.
// ----------------------------------------------------------------------------
module qalu_mul #(
  parameter int FRAC_BITS = qalu_pkg::QALU_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_v,
  input  qalu_pkg::tag_t                in_tag,
  input  logic [3:0][31:0]              in_a,
  input  logic [3:0][31:0]              in_b,
  output logic                          out_v,
  output qalu_pkg::tag_t                out_tag,
  output logic [3:0][31:0]              out_a,
  output logic [3:0][31:0]              out_b,
  output logic [15:0][63-FRAC_BITS:0]   out_p
);
  import qalu_pkg::*;

  logic             s1_v;
  tag_t             s1_tag;
  logic [3:0][31:0] s1_a;
  logic [3:0][31:0] s1_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v  <= 1'b0;
      out_v <= 1'b0;
    end else if (en) begin
      s1_v  <= in_v;
      out_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_tag  <= in_tag;
      s1_a    <= in_a;
      s1_b    <= in_b;
      out_tag <= s1_tag;
      out_a   <= s1_a;
      out_b   <= s1_b;
    end
  end

  for (genvar x = 0; x < 4; x++) begin : g_x
    for (genvar y = 0; y < 4; y++) begin : g_y
      logic signed [63:0] full;
      assign full = $signed(s1_a[x]) * $signed(s1_b[y]);
      always_ff @(posedge clk) begin
        if (en) begin
          out_p[x*4+y] <= full[63:FRAC_BITS];
        end
      end
    end
  end

endmodule

// ===== rtl/qalu_sum.sv =====
// ----------------------------------------------------------------------------
// qalu_sum
// Combines operands or shifted products into exact sums for each command and
// matrix row, forms the squared norm and the magnitudes for the inverse.
// ----------------------------------------------------------------------------
module qalu_sum #(
  parameter int FRAC_BITS = qalu_pkg::QALU_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_v,
  input  qalu_pkg::tag_t                in_tag,
  input  logic [3:0][31:0]              in_a,
  input  logic [3:0][31:0]              in_b,
  input  logic [15:0][63-FRAC_BITS:0]   in_p,
  output logic                          out_v,
  output qalu_pkg::tag_t                out_tag,
  output logic [3:0][67-FRAC_BITS:0]    out_t,
  output logic [64-FRAC_BITS:0]         out_n,
  output logic [3:0]                    out_neg,
  output logic [3:0][31:0]              out_mag
);
  import qalu_pkg::*;

  localparam int PW = 64 - FRAC_BITS;
  localparam int SW = 68 - FRAC_BITS;
  localparam int NW = 65 - FRAC_BITS;

  logic signed [SW-1:0] e [16];
  logic signed [SW-1:0] ea [4];
  logic signed [SW-1:0] eb [4];
  logic signed [SW-1:0] t [4];
  logic signed [SW-1:0] nsum;
  logic [3:0][31:0]     mag;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      e[i] = {{(SW-PW){in_p[i][PW-1]}}, in_p[i]};
    end
    for (int i = 0; i < 4; i++) begin
      ea[i]  = {{(SW-32){in_a[i][31]}}, in_a[i]};
      eb[i]  = {{(SW-32){in_b[i][31]}}, in_b[i]};
      mag[i] = in_a[i][31] ? (~in_a[i] + 32'd1) : in_a[i];
    end
    nsum = e[0] + e[5] + e[10] + e[15];
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      t[i] = '0;
    end
    case (in_tag.cmd)
      CMD_ADD: begin
        for (int i = 0; i < 4; i++) begin
          t[i] = ea[i] + eb[i];
        end
      end
      CMD_SUB: begin
        for (int i = 0; i < 4; i++) begin
          t[i] = ea[i] - eb[i];
        end
      end
      CMD_MUL: begin
        t[0] = e[0] - e[5] - e[10] - e[15];
        t[1] = e[1] + e[4] + e[11] - e[14];
        t[2] = e[2] - e[7] + e[8] + e[13];
        t[3] = e[3] + e[6] - e[9] + e[12];
      end
      CMD_ROT: begin
        case (in_tag.row)
          2'd0: begin
            t[0] = e[0] + e[5] - e[10] - e[15];
            t[1] = (e[6] - e[3]) <<< 1;
            t[2] = (e[7] + e[2]) <<< 1;
          end
          2'd1: begin
            t[0] = (e[6] + e[3]) <<< 1;
            t[1] = e[0] - e[5] + e[10] - e[15];
            t[2] = (e[11] - e[1]) <<< 1;
          end
          default: begin
            t[0] = (e[7] - e[2]) <<< 1;
            t[1] = (e[11] + e[1]) <<< 1;
            t[2] = e[0] - e[5] - e[10] + e[15];
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tag <= in_tag;
      for (int i = 0; i < 4; i++) begin
        out_t[i]   <= t[i];
        out_neg[i] <= in_a[i][31];
      end
      out_mag <= mag;
      out_n   <= nsum[NW-1:0];
    end
  end

endmodule

// ===== rtl/qalu_div.sv =====
// ----------------------------------------------------------------------------
// qalu_div
// Four restoring dividers sharing one divisor, one quotient bit per cycle,
// for the scaled magnitudes of a over the squared norm.
// ----------------------------------------------------------------------------
module qalu_div #(
  parameter int FRAC_BITS = qalu_pkg::QALU_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  qalu_pkg::div_ctl_t            ctl,
  input  logic [3:0][31:0]              mag,
  input  logic [64-FRAC_BITS:0]         n,
  output logic                          done,
  output logic [3:0][FRAC_BITS+31:0]    q
);
  import qalu_pkg::*;

  localparam int NW = 65 - FRAC_BITS;
  localparam int DW = FRAC_BITS + 32;
  localparam int CW = $clog2(DW + 1);

  div_state_t       state;
  div_state_t       state_next;
  logic [CW-1:0]    cnt;
  logic [NW-1:0]    rem [4];
  logic [NW-1:0]    rem_next [4];
  logic [NW:0]      trial [4];
  logic [NW:0]      diff [4];
  logic [3:0]       qbit;
  logic             load;
  logic             shift;

  always_comb begin
    state_next = state;
    unique case (state)
      DIV_IDLE: if (ctl.start) state_next = DIV_RUN;
      DIV_RUN:  if (cnt == CW'(1)) state_next = DIV_DONE;
      DIV_DONE: if (ctl.ack) state_next = DIV_IDLE;
      default:  state_next = DIV_IDLE;
    endcase
  end

  always_comb begin
    load  = (state == DIV_IDLE) && ctl.start;
    shift = (state == DIV_RUN);
    done  = (state == DIV_DONE);
  end

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      trial[l]    = {rem[l], q[l][DW-1]};
      diff[l]     = trial[l] - {1'b0, n};
      qbit[l]     = (trial[l] >= {1'b0, n});
      rem_next[l] = qbit[l] ? diff[l][NW-1:0] : trial[l][NW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DIV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cnt <= CW'(DW);
      for (int l = 0; l < 4; l++) begin
        rem[l] <= '0;
        q[l]   <= {mag[l], {FRAC_BITS{1'b0}}};
      end
    end else if (shift) begin
      cnt <= cnt - CW'(1);
      for (int l = 0; l < 4; l++) begin
        rem[l] <= rem_next[l];
        q[l]   <= {q[l][DW-2:0], qbit[l]};
      end
    end
  end

endmodule

// ===== rtl/quaternion_alu_top.sv =====
// ----------------------------------------------------------------------------
// quaternion_alu_top
// Fixed-point quaternion unit: add, subtract, Hamilton product, inverse and
// rotation matrix, with saturation and status per result.
//
//   Channel   Handshake             Payload
//   request   req_valid/req_stall   command, a_r..a_k, b_r..b_k
//   response  rsp_valid/rsp_stall   v0..v3, row, last, status
//
// Add, subtract and multiply issue once each; a matrix item holds the issue
// register while it issues its rows one at a time. A response passes the issue
// register, the operand and product registers of the multiplier, the sum
// register and the output register. An inverse with nonzero norm stalls the
// stages before the output while the divider makes one quotient bit per cycle.
// Reset clears all valid bits and the divider state machine.
// A stalled response freezes every occupied stage but the divider; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module quaternion_alu_top #(
  parameter int FRAC_BITS = qalu_pkg::QALU_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [2:0]         command,
  input  logic signed [31:0] a_r,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] a_j,
  input  logic signed [31:0] a_k,
  input  logic signed [31:0] b_r,
  input  logic signed [31:0] b_i,
  input  logic signed [31:0] b_j,
  input  logic signed [31:0] b_k,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output logic signed [31:0] v0,
  output logic signed [31:0] v1,
  output logic signed [31:0] v2,
  output logic signed [31:0] v3,
  output logic [1:0]         row,
  output logic               last,
  output logic [1:0]         status
);
  import qalu_pkg::*;

  localparam int PW = 64 - FRAC_BITS;
  localparam int SW = 68 - FRAC_BITS;
  localparam int NW = 65 - FRAC_BITS;
  localparam int DW = FRAC_BITS + 32;

  logic             h_v;
  logic [2:0]       h_cmd;
  logic [3:0][31:0] h_a;
  logic [3:0][31:0] h_b;
  logic [1:0]       h_row;
  logic             h_final;
  logic             h_known;
  logic             accept;
  logic             en;
  tag_t             iss_tag;
  logic [3:0][31:0] iss_b;

  logic             s2_v;
  tag_t             s2_tag;
  logic [3:0][31:0] s2_a;
  logic [3:0][31:0] s2_b;
  logic [15:0][PW-1:0] s2_p;

  logic             s3_v;
  tag_t             s3_tag;
  logic [3:0][SW-1:0] s3_t;
  logic [NW-1:0]    s3_n;
  logic [3:0]       s3_neg;
  logic [3:0][31:0] s3_mag;

  div_ctl_t         div_ctl;
  logic             div_done;
  logic [3:0][DW-1:0] div_q;

  logic             need;
  logic             goes;
  logic             out_free;
  logic [31:0]      res [4];
  logic [3:0]       ovf;
  logic             negr;
  logic [1:0]       res_st;

  assign h_final = (h_cmd != CMD_ROT) || (h_row == ROW_LAST);
  assign h_known = (h_cmd == CMD_ADD) || (h_cmd == CMD_SUB) || (h_cmd == CMD_MUL) ||
                   (h_cmd == CMD_INV) || (h_cmd == CMD_ROT);
  assign req_stall = h_v && !(en && h_final);
  assign accept    = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      h_v   <= 1'b0;
      h_row <= 2'd0;
    end else if (accept) begin
      h_v   <= 1'b1;
      h_row <= 2'd0;
    end else if (en && h_v) begin
      if (h_final) begin
        h_v <= 1'b0;
      end else begin
        h_row <= h_row + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      h_cmd <= command;
      h_a   <= {a_k, a_j, a_i, a_r};
      h_b   <= {b_k, b_j, b_i, b_r};
    end
  end

  assign iss_tag = '{cmd: cmd_t'(h_cmd), row: h_row, last: h_final};
  assign iss_b   = ((h_cmd == CMD_INV) || (h_cmd == CMD_ROT)) ? h_a : h_b;

  qalu_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .in_v   (h_v && h_known),
    .in_tag (iss_tag),
    .in_a   (h_a),
    .in_b   (iss_b),
    .out_v  (s2_v),
    .out_tag(s2_tag),
    .out_a  (s2_a),
    .out_b  (s2_b),
    .out_p  (s2_p)
  );

  qalu_sum #(.FRAC_BITS(FRAC_BITS)) u_sum (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .in_v   (s2_v),
    .in_tag (s2_tag),
    .in_a   (s2_a),
    .in_b   (s2_b),
    .in_p   (s2_p),
    .out_v  (s3_v),
    .out_tag(s3_tag),
    .out_t  (s3_t),
    .out_n  (s3_n),
    .out_neg(s3_neg),
    .out_mag(s3_mag)
  );

  assign need     = s3_v && (s3_tag.cmd == CMD_INV) && (s3_n != '0);
  assign goes     = !need || div_done;
  assign out_free = !rsp_valid || !rsp_stall;
  assign en       = out_free && goes;

  assign div_ctl.start = need;
  assign div_ctl.ack   = en && need;

  qalu_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk (clk),
    .rst (rst),
    .ctl (div_ctl),
    .mag (s3_mag),
    .n   (s3_n),
    .done(div_done),
    .q   (div_q)
  );

  always_comb begin
    negr   = 1'b0;
    res_st = ST_OK;
    for (int l = 0; l < 4; l++) begin
      res[l] = '0;
      ovf[l] = 1'b0;
    end
    if (s3_tag.cmd == CMD_INV) begin
      if (s3_n == '0) begin
        res_st = ST_ZERO;
      end else begin
        for (int l = 0; l < 4; l++) begin
          negr = s3_neg[l] ^ (l != 0);
          if (negr) begin
            ovf[l] = (div_q[l][DW-1:32] != '0) ||
                     (div_q[l][31] && (div_q[l][30:0] != '0));
            res[l] = ovf[l] ? SAT_MIN : (~div_q[l][31:0] + 32'd1);
          end else begin
            ovf[l] = (div_q[l][DW-1:31] != '0);
            res[l] = ovf[l] ? SAT_MAX : div_q[l][31:0];
          end
        end
        res_st = (ovf != 4'd0) ? ST_SAT : ST_OK;
      end
    end else begin
      for (int l = 0; l < 4; l++) begin
        ovf[l] = (s3_t[l][SW-1:31] != {(SW-31){s3_t[l][SW-1]}});
        res[l] = ovf[l] ? (s3_t[l][SW-1] ? SAT_MIN : SAT_MAX) : s3_t[l][31:0];
      end
      res_st = (ovf != 4'd0) ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_free) begin
      rsp_valid <= s3_v && goes;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s3_v && goes) begin
      v0     <= res[0];
      v1     <= res[1];
      v2     <= res[2];
      v3     <= res[3];
      row    <= s3_tag.row;
      last   <= s3_tag.last;
      status <= res_st;
    end
  end

endmodule

// ===== rtl/qalu_check.sv =====
// ----------------------------------------------------------------------------
// qalu_check
// Port-level checks on the response channel of the quaternion unit, bound
// to the top level.
// ----------------------------------------------------------------------------
module qalu_check (
  input logic               clk,
  input logic               rst,
  input logic               rsp_valid,
  input logic               rsp_stall,
  input logic signed [31:0] v0,
  input logic signed [31:0] v1,
  input logic signed [31:0] v2,
  input logic signed [31:0] v3,
  input logic [1:0]         row,
  input logic               last,
  input logic [1:0]         status
);
  import qalu_pkg::*;

  a_reset_idle: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid &&
      $stable({v0, v1, v2, v3, row, last, status}))
    else $error("stalled response transfer changed");

  a_row_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (row == ROW_LAST) |-> last)
    else $error("final matrix row not marked last");

  a_zero_norm: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == ST_ZERO) |->
      (v0 == 0) && (v1 == 0) && (v2 == 0) && (v3 == 0) && (row == 2'd0) && last)
    else $error("zero norm result not all zeros");

  a_row_v3: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (row != 2'd0) |-> (v3 == 0) && (status != ST_ZERO))
    else $error("matrix row with nonzero fourth column");

endmodule

bind quaternion_alu_top qalu_check u_qalu_check (
  .clk      (clk),
  .rst      (rst),
  .rsp_valid(rsp_valid),
  .rsp_stall(rsp_stall),
  .v0       (v0),
  .v1       (v1),
  .v2       (v2),
  .v3       (v3),
  .row      (row),
  .last     (last),
  .status   (status)
);
